>>> sv/pba_pkg.sv
// pba_pkg: shared constants, status codes and beat types of the page allocator
// depends on nothing
package pba_pkg;

  localparam int MAP_WORDS_DEF = 16;
  // page size, a power of two
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  localparam int ADDR_W     = 64;
  localparam int STATUS_W   = 3;
  localparam int PAGE_NUM_W = 10;
  localparam int COUNT_W    = 11;
  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = 6;
  localparam int CFG_IDX_W  = 1;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT  = 1'd1;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NULL       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_USED   = 3'd5;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [ADDR_W-1:0]     page_address;
    logic [PAGE_NUM_W-1:0] page_number;
    logic [COUNT_W-1:0]    pages_in_use;
  } rsp_t;

  typedef struct packed {
    logic                cap_in;
    logic                scan_first;
    logic                scan_next;
    logic                capture;
    logic                acq_commit;
    logic                calc_offset;
    logic                rel_read;
    logic                rel_commit;
    logic                set_res;
    logic [STATUS_W-1:0] res_code;
    logic                res_use_idx;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic addr_zero;
    logic limit_hit;
    logic word_full;
    logic last_word;
    logic misaligned;
    logic out_of_range;
    logic bit_used;
    logic out_busy;
  } stat_t;

endpackage

>>> sv/page_bitmap_allocator.sv
// page_bitmap_allocator: first-fit page allocator, one request in flight at a time.
// acquire scans bitmap words from word 0, one ram read per cycle, until one has a free
// bit, and ends at once when the limit is already reached. release checks the address,
// reads its bitmap word and clears the bit. a new beat is taken once the result is loaded.
// rst is synchronous: bitmap reads as all free, count zero, region_base 0, limit 1024.
// depends on pba_pkg, pba_ctrl, pba_datapath and pba_ram
module page_bitmap_allocator import pba_pkg::*; #(
  parameter int MAP_WORDS = MAP_WORDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  req_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rsp_t                 out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_data.op),
    .stat     (stat),
    .cmd      (cmd)
  );

  pba_datapath #(
    .MAP_WORDS (MAP_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sv/pba_ram.sv
// pba_ram: generic single write port, single read port ram with registered read
// depends on nothing
module pba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/pba_datapath.sv
// pba_datapath: bitmap ram, word valid bits, config registers, page count,
// release offset arithmetic and output register; uses pba_pkg and pba_ram
module pba_datapath import pba_pkg::*; #(
  parameter int MAP_WORDS = MAP_WORDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  req_t                 in_data,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rsp_t                 out_data
);

  localparam int WA_W        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int TOTAL_PAGES = MAP_WORDS * WORD_BITS;
  localparam int IDX_W       = $clog2(TOTAL_PAGES);

  logic [ADDR_W-1:0]     region_base;
  logic [COUNT_W-1:0]    page_limit;
  logic [COUNT_W-1:0]    used_count;
  logic [ADDR_W-1:0]     addr_q;
  logic [ADDR_W-1:0]     offset_q;
  logic [WA_W-1:0]       chk_ptr;
  logic [WORD_BITS-1:0]  hold_word;
  logic [BIT_W-1:0]      hold_bit;
  logic [MAP_WORDS-1:0]  word_valid;
  logic                  vld_q;
  logic [STATUS_W-1:0]   res_status;
  logic [ADDR_W-1:0]     res_address;
  logic [PAGE_NUM_W-1:0] res_number;

  logic [WA_W-1:0]       ram_raddr;
  logic [WA_W-1:0]       ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [WORD_BITS-1:0]  ram_rdata;
  logic                  ram_we;
  logic [WORD_BITS-1:0]  eff_word;
  logic [BIT_W-1:0]      low_clear;
  logic [IDX_W-1:0]      rel_idx;
  logic [WA_W-1:0]       rel_word;
  logic [BIT_W-1:0]      rel_bit;
  logic [IDX_W-1:0]      acq_idx;

  pba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // words never written read as all free
  assign eff_word = vld_q ? ram_rdata : '0;

  always_comb begin
    low_clear = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!eff_word[i]) begin
        low_clear = BIT_W'(i);
      end
    end
  end

  assign rel_idx  = IDX_W'(offset_q >> PAGE_SHIFT);
  assign rel_word = WA_W'(rel_idx >> BIT_W);
  assign rel_bit  = rel_idx[BIT_W-1:0];
  assign acq_idx  = (IDX_W'(chk_ptr) << BIT_W) | IDX_W'(hold_bit);

  always_comb begin
    priority if (cmd.scan_first) begin
      ram_raddr = '0;
    end else if (cmd.scan_next) begin
      ram_raddr = chk_ptr + 1'b1;
    end else if (cmd.rel_read) begin
      ram_raddr = rel_word;
    end else begin
      ram_raddr = chk_ptr;
    end
  end

  assign ram_we    = cmd.acq_commit | cmd.rel_commit;
  assign ram_waddr = cmd.acq_commit ? chk_ptr : rel_word;
  assign ram_wdata = cmd.acq_commit ? (hold_word | (64'd1 << hold_bit))
                                    : (eff_word & ~(64'd1 << rel_bit));

  assign stat.addr_zero    = (addr_q == '0);
  assign stat.limit_hit    = (used_count >= page_limit);
  assign stat.word_full    = &eff_word;
  assign stat.last_word    = (chk_ptr == WA_W'(MAP_WORDS - 1));
  assign stat.misaligned   = ((offset_q & ADDR_W'(PAGE_BYTES - 1)) != '0);
  assign stat.out_of_range = ((offset_q >> PAGE_SHIFT) >= ADDR_W'(TOTAL_PAGES));
  assign stat.bit_used     = eff_word[rel_bit];
  assign stat.out_busy     = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      page_limit  <= LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_REGION_BASE: region_base <= cfg_data;
        CFG_PAGE_LIMIT:  page_limit  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      word_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.acq_commit) begin
        used_count          <= used_count + 1'b1;
        word_valid[chk_ptr] <= 1'b1;
      end else if (cmd.rel_commit) begin
        if (used_count != '0) begin
          used_count <= used_count - 1'b1;
        end
        word_valid[rel_word] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_q <= word_valid[ram_raddr];
    if (cmd.cap_in) begin
      addr_q <= in_data.address;
    end
    if (cmd.calc_offset) begin
      offset_q <= addr_q - region_base;
    end
    if (cmd.scan_first) begin
      chk_ptr <= '0;
    end else if (cmd.scan_next) begin
      chk_ptr <= chk_ptr + 1'b1;
    end
    if (cmd.capture) begin
      hold_word <= eff_word;
      hold_bit  <= low_clear;
    end
    priority if (cmd.acq_commit) begin
      res_status  <= ST_OK;
      res_address <= region_base + (ADDR_W'(acq_idx) << PAGE_SHIFT);
      res_number  <= PAGE_NUM_W'(acq_idx);
    end else if (cmd.rel_commit) begin
      res_status  <= ST_OK;
      res_address <= '0;
      res_number  <= PAGE_NUM_W'(rel_idx);
    end else if (cmd.set_res) begin
      res_status  <= cmd.res_code;
      res_address <= '0;
      res_number  <= cmd.res_use_idx ? PAGE_NUM_W'(rel_idx) : '0;
    end
    if (cmd.out_load) begin
      out_data.status       <= res_status;
      out_data.page_address <= res_address;
      out_data.page_number  <= res_number;
      out_data.pages_in_use <= used_count;
    end
  end

endmodule

>>> sv/pba_ctrl.sv
// pba_ctrl: request sequencer for acquire scan and release check
// depends on pba_pkg; drives pba_datapath through cmd_t and reads stat_t
module pba_ctrl import pba_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  in_op,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_ACQ_START  = 3'd1;
  localparam logic [2:0] S_ACQ_SCAN   = 3'd2;
  localparam logic [2:0] S_ACQ_SET    = 3'd3;
  localparam logic [2:0] S_REL_OFFSET = 3'd4;
  localparam logic [2:0] S_REL_CLASS  = 3'd5;
  localparam logic [2:0] S_REL_READ   = 3'd6;
  localparam logic [2:0] S_RESULT     = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_next = (in_op == OP_RELEASE) ? S_REL_OFFSET : S_ACQ_START;
        end
      end
      S_ACQ_START: begin
        if (stat.limit_hit) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NO_FREE;
          state_next   = S_RESULT;
        end else begin
          cmd.scan_first = 1'b1;
          state_next     = S_ACQ_SCAN;
        end
      end
      S_ACQ_SCAN: begin
        priority if (!stat.word_full) begin
          cmd.capture = 1'b1;
          state_next  = S_ACQ_SET;
        end else if (stat.last_word) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NO_FREE;
          state_next   = S_RESULT;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_ACQ_SET: begin
        cmd.acq_commit = 1'b1;
        state_next     = S_RESULT;
      end
      S_REL_OFFSET: begin
        if (stat.addr_zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NULL;
          state_next   = S_RESULT;
        end else begin
          cmd.calc_offset = 1'b1;
          state_next      = S_REL_CLASS;
        end
      end
      S_REL_CLASS: begin
        priority if (stat.misaligned) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_MISALIGNED;
          state_next   = S_RESULT;
        end else if (stat.out_of_range) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_RANGE;
          state_next   = S_RESULT;
        end else begin
          cmd.rel_read = 1'b1;
          state_next   = S_REL_READ;
        end
      end
      S_REL_READ: begin
        if (stat.bit_used) begin
          cmd.rel_commit = 1'b1;
        end else begin
          cmd.set_res     = 1'b1;
          cmd.res_code    = ST_NOT_USED;
          cmd.res_use_idx = 1'b1;
        end
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.acq_commit, cmd.rel_commit, cmd.set_res}))
    else $error("more than one result source in a cycle");

  a_rel_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.rel_commit |-> $past(cmd.rel_read))
    else $error("release commit without a bitmap read");

  a_acq_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.acq_commit |-> $past(cmd.capture))
    else $error("acquire commit without a captured word");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new beat taken while a request is in flight");
`endif

endmodule
